FILE: design/alar_pkg.sv
`timescale 1ns / 1ps

package alar_pkg;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] value;
		logic        [7:0]  position;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] removed_value;
		logic        [8:0]  count;
		logic        [8:0]  capacity;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CAPTURE,
		S_SHIFT,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic capture;
		logic shift;
		logic publish;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rm_go;
		logic more_cap;
		logic more_shift;
		logic out_busy;
	} dp_sts_t;

endpackage

FILE: design/array_list_append_remove_core.sv
`timescale 1ns / 1ps

// Channel  Signals                        Payload
// req      req_valid / req_stall / req    opcode, value, position
// rsp      rsp_valid / rsp_stall / rsp    status, removed_value, count, capacity
//
// An append or a failed remove goes from the take straight to the finish step;
// a successful remove at position p with count n captures the removed word,
// then shifts the n - 1 - p words above p down via the store's single write port.
// Reset clears the count and sets the capacity to the minimum; the store is not
// cleared. A new transaction is taken while the last result waits in the output
// register; a stalled result holds the block in its finish step.

module array_list_append_remove_core #(
	parameter int STORE_DEPTH = 256,
	parameter int MIN_CAP     = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  alar_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output alar_pkg::rsp_t rsp
);

	import alar_pkg::*;

	// Command and status are the only link between sequencer and datapath.
	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// Sequencer: take the transaction, capture the removed word, walk the
	// shift, then publish into the output register.
	alar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: count and capacity registers, element store, result staging
	// and output register.
	alar_dp #(
		.STORE_DEPTH(STORE_DEPTH),
		.MIN_CAP    (MIN_CAP)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

FILE: design/alar_ram.sv
`timescale 1ns / 1ps

module alar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/alar_ctrl.sv
`timescale 1ns / 1ps

module alar_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  alar_pkg::dp_sts_t  sts,
	output alar_pkg::ctl_cmd_t cmd
);

	import alar_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = sts.rm_go ? S_CAPTURE : S_FINISH;
				end
			end
			S_CAPTURE: begin
				state_d = sts.more_cap ? S_SHIFT : S_FINISH;
			end
			S_SHIFT: begin
				state_d = sts.more_shift ? S_SHIFT : S_FINISH;
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.take  = req_valid;
			end
			S_CAPTURE: begin
				cmd.capture = 1'b1;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
			end
			S_FINISH: begin
				cmd.publish = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: design/alar_dp.sv
`timescale 1ns / 1ps

module alar_dp #(
	parameter int STORE_DEPTH = 256,
	parameter int MIN_CAP     = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  alar_pkg::req_t     req,
	input  alar_pkg::ctl_cmd_t cmd,
	output alar_pkg::dp_sts_t  sts,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output alar_pkg::rsp_t     rsp
);

	import alar_pkg::*;

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int CW    = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;
	localparam int CAP_RST_I = (MIN_CAP > STORE_DEPTH) ? STORE_DEPTH : MIN_CAP;
	localparam logic [CW-1:0]    MIN_W   = CW'(MIN_CAP);
	localparam logic [CW-1:0]    DEPTH_W = CW'(STORE_DEPTH);
	localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(CAP_RST_I);

	function automatic logic [CW-1:0] clamp_cap(input logic [CW-1:0] c);
		logic [CW-1:0] r;
		r = (c < MIN_W) ? MIN_W : c;
		r = (r > DEPTH_W) ? DEPTH_W : r;
		return r;
	endfunction

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_q;
	logic [AW-1:0]    ptr_q;
	rsp_t             res_q;
	rsp_t             out_q;
	logic             out_valid_q;

	logic [CW-1:0] cnt_w, cap_w, pos_w, ptr_w;
	logic [CW-1:0] cnt_nxt, cap_nxt;
	logic          is_rm, rm_ok, full, app_ok;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;

	always_comb begin
		cnt_w  = CW'(count_q);
		cap_w  = CW'(cap_q);
		pos_w  = CW'(req.position);
		ptr_w  = CW'(ptr_q);
		is_rm  = (req.opcode == OP_REMOVE);
		rm_ok  = is_rm && (pos_w < cnt_w);
		full   = (cnt_w == DEPTH_W);
		app_ok = !is_rm && !full;

		cnt_nxt = cnt_w;
		cap_nxt = cap_w;
		if (app_ok) begin
			cnt_nxt = cnt_w + CW'(1);
			if (cnt_w >= cap_w) begin
				cap_nxt = clamp_cap(cap_w << 1);
			end
		end else if (rm_ok) begin
			cnt_nxt = cnt_w - CW'(1);
			if ((cap_w > MIN_W) && (cnt_nxt < (cap_w >> 1))) begin
				cap_nxt = clamp_cap(cap_w >> 1);
			end
		end
	end

	// count_q already holds the decremented count while the shift runs
	always_comb begin
		sts.rm_go      = rm_ok;
		sts.more_cap   = ptr_w < cnt_w;
		sts.more_shift = (ptr_w + CW'(1)) < cnt_w;
		sts.out_busy   = out_valid_q && rsp_stall;
	end

	always_comb begin
		mem_we    = (cmd.take && app_ok) || cmd.shift;
		mem_waddr = cmd.shift ? ptr_q : count_q[AW-1:0];
		mem_wdata = cmd.shift ? mem_rdata : req.value;
		if (cmd.capture) begin
			mem_raddr = ptr_q + AW'(1);
		end else if (cmd.shift) begin
			mem_raddr = ptr_q + AW'(2);
		end else begin
			mem_raddr = pos_w[AW-1:0];
		end
	end

	alar_ram #(
		.WIDTH(32),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				count_q <= cnt_nxt[CNT_W-1:0];
				cap_q   <= cap_nxt[CNT_W-1:0];
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ptr_q               <= pos_w[AW-1:0];
			res_q.removed_value <= '0;
			res_q.count         <= 9'(cnt_nxt);
			res_q.capacity      <= 9'(cap_nxt);
			if (is_rm) begin
				res_q.status <= rm_ok ? ST_OK : ST_RANGE;
			end else begin
				res_q.status <= full ? ST_FULL : ST_OK;
			end
		end
		if (cmd.capture) begin
			res_q.removed_value <= mem_rdata;
		end
		if (cmd.shift) begin
			ptr_q <= ptr_q + AW'(1);
		end
		if (cmd.publish) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
